// ----- rtl/plf_pkg.sv -----
// ----------------------------------------------------------------------------
// plf_pkg
// Shared constants and sideband types for the plane-from-three-points pipe.
// ----------------------------------------------------------------------------
package plf_pkg;

    // Default fraction bits of the coordinates and of the unit normal
    localparam int COORD_FRAC_BITS_DEF  = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 30;

    // Scaled normal components keep 31 significant bits
    localparam int A_W   = 31;
    // Sum of three squared components, and its integer square root
    localparam int SUM_W = 64;
    localparam int LEN_W = 32;

    // Square root: one result bit per iteration, two iterations per stage
    localparam int SQRT_ITERS = 32;
    localparam int SQRT_STEPS = 2;

    // Divider: quotient bits resolved per stage
    localparam int DIV_STEPS = 2;

    // Per-item sideband that rides along with the arithmetic
    typedef struct packed {
        logic             ok;
        logic [2:0]       neg;
        logic [2:0][31:0] p0;
    } plf_tag_t;

    // Sideband through the square-root pipe: tag plus scaled components
    typedef struct packed {
        plf_tag_t            tag;
        logic [2:0][A_W-1:0] a;
    } plf_sq_side_t;

endpackage

// ----- rtl/plf_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// plf_sqrt_pipe
// Pipelined integer square root of a 64-bit value, two result bits a stage.
// ----------------------------------------------------------------------------
module plf_sqrt_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [63:0]          in_sum,
    input  plf_pkg::plf_sq_side_t in_side,
    output logic                 out_valid,
    output logic [31:0]          out_len,
    output plf_pkg::plf_sq_side_t out_side
);
    import plf_pkg::*;

    localparam int STAGES = SQRT_ITERS / SQRT_STEPS;

    logic         valid_reg [STAGES];
    logic [63:0]  x_reg     [STAGES];
    logic [63:0]  res_reg   [STAGES];
    plf_sq_side_t side_reg  [STAGES];

    logic         valid_src [STAGES];
    logic [63:0]  x_src     [STAGES];
    logic [63:0]  res_src   [STAGES];
    plf_sq_side_t side_src  [STAGES];

    logic [63:0]  x_next    [STAGES];
    logic [63:0]  res_next  [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        // Select the stage input: port for the first stage, previous stage otherwise
        if (j == 0) begin : g_first
            assign valid_src[j] = in_valid;
            assign x_src[j]     = in_sum;
            assign res_src[j]   = '0;
            assign side_src[j]  = in_side;
        end
        else begin : g_rest
            assign valid_src[j] = valid_reg[j-1];
            assign x_src[j]     = x_reg[j-1];
            assign res_src[j]   = res_reg[j-1];
            assign side_src[j]  = side_reg[j-1];
        end

        // Resolve two root bits
        always_comb
        begin
            logic [63:0] x_v;
            logic [63:0] r_v;
            logic [63:0] step_bit;
            x_v = x_src[j];
            r_v = res_src[j];
            for (int t = 0; t < SQRT_STEPS; t++)
            begin
                step_bit = 64'd1 << (62 - 2 * (j * SQRT_STEPS + t));
                if (x_v >= r_v + step_bit)
                begin
                    x_v = x_v - (r_v + step_bit);
                    r_v = (r_v >> 1) + step_bit;
                end
                else
                begin
                    r_v = r_v >> 1;
                end
            end
            x_next[j]   = x_v;
            res_next[j] = r_v;
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_src[j];
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            x_reg[j]    <= x_next[j];
            res_reg[j]  <= res_next[j];
            side_reg[j] <= side_src[j];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_len   = res_reg[STAGES-1][LEN_W-1:0];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ----- rtl/plf_div_pipe.sv -----
// ----------------------------------------------------------------------------
// plf_div_pipe
// Three-lane pipelined restoring divider: round(a * 2^F / len), two bits a stage.
// ----------------------------------------------------------------------------
module plf_div_pipe #(
    parameter int NORMAL_FRAC_BITS = plf_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [2:0][plf_pkg::A_W-1:0]        in_a,
    input  logic [plf_pkg::LEN_W-1:0]           in_len,
    input  plf_pkg::plf_tag_t                   in_tag,
    output logic                                out_valid,
    output logic [2:0][NORMAL_FRAC_BITS:0]      out_quo,
    output plf_pkg::plf_tag_t                   out_tag
);
    import plf_pkg::*;

    localparam int Q_STEPS = NORMAL_FRAC_BITS + 1;
    localparam int STAGES  = (Q_STEPS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_W   = A_W + NORMAL_FRAC_BITS + 1;

    // Entry stage: numerator split into a starting remainder and the low bits
    logic                              e_valid_reg;
    logic [2:0][LEN_W-1:0]             e_rem_reg;
    logic [2:0][NORMAL_FRAC_BITS:0]    e_low_reg;
    logic [LEN_W-1:0]                  e_len_reg;
    plf_tag_t                          e_tag_reg;
    logic [2:0][LEN_W-1:0]             e_rem_next;
    logic [2:0][NORMAL_FRAC_BITS:0]    e_low_next;

    // Form the rounded numerator and split it
    always_comb
    begin
        logic [NUM_W-1:0] num_v;
        for (int i = 0; i < 3; i++)
        begin
            num_v = (NUM_W'(in_a[i]) << NORMAL_FRAC_BITS) + NUM_W'(in_len >> 1);
            e_rem_next[i] = LEN_W'(num_v >> (NORMAL_FRAC_BITS + 1));
            e_low_next[i] = num_v[NORMAL_FRAC_BITS:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e_rem_reg <= e_rem_next;
        e_low_reg <= e_low_next;
        e_len_reg <= in_len;
        e_tag_reg <= in_tag;
    end

    logic                           valid_reg [STAGES];
    logic [2:0][LEN_W-1:0]          rem_reg   [STAGES];
    logic [2:0][NORMAL_FRAC_BITS:0] low_reg   [STAGES];
    logic [2:0][NORMAL_FRAC_BITS:0] quo_reg   [STAGES];
    logic [LEN_W-1:0]               len_reg   [STAGES];
    plf_tag_t                       tag_reg   [STAGES];

    logic                           valid_src [STAGES];
    logic [2:0][LEN_W-1:0]          rem_src   [STAGES];
    logic [2:0][NORMAL_FRAC_BITS:0] low_src   [STAGES];
    logic [2:0][NORMAL_FRAC_BITS:0] quo_src   [STAGES];
    logic [LEN_W-1:0]               len_src   [STAGES];
    plf_tag_t                       tag_src   [STAGES];

    logic [2:0][LEN_W-1:0]          rem_next  [STAGES];
    logic [2:0][NORMAL_FRAC_BITS:0] low_next  [STAGES];
    logic [2:0][NORMAL_FRAC_BITS:0] quo_next  [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        // Select the stage input
        if (j == 0) begin : g_first
            assign valid_src[j] = e_valid_reg;
            assign rem_src[j]   = e_rem_reg;
            assign low_src[j]   = e_low_reg;
            assign quo_src[j]   = '0;
            assign len_src[j]   = e_len_reg;
            assign tag_src[j]   = e_tag_reg;
        end
        else begin : g_rest
            assign valid_src[j] = valid_reg[j-1];
            assign rem_src[j]   = rem_reg[j-1];
            assign low_src[j]   = low_reg[j-1];
            assign quo_src[j]   = quo_reg[j-1];
            assign len_src[j]   = len_reg[j-1];
            assign tag_src[j]   = tag_reg[j-1];
        end

        // Resolve up to two quotient bits in each lane
        always_comb
        begin
            logic [2:0][LEN_W-1:0]          rem_v;
            logic [2:0][NORMAL_FRAC_BITS:0] low_v;
            logic [2:0][NORMAL_FRAC_BITS:0] quo_v;
            logic [LEN_W:0]                 rem2;
            rem_v = rem_src[j];
            low_v = low_src[j];
            quo_v = quo_src[j];
            for (int t = 0; t < DIV_STEPS; t++)
            begin
                if (j * DIV_STEPS + t < Q_STEPS)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rem2     = {rem_v[i], low_v[i][NORMAL_FRAC_BITS]};
                        low_v[i] = low_v[i] << 1;
                        if (rem2 >= {1'b0, len_src[j]})
                        begin
                            rem2     = rem2 - {1'b0, len_src[j]};
                            quo_v[i] = {quo_v[i][NORMAL_FRAC_BITS-1:0], 1'b1};
                        end
                        else
                        begin
                            quo_v[i] = {quo_v[i][NORMAL_FRAC_BITS-1:0], 1'b0};
                        end
                        rem_v[i] = rem2[LEN_W-1:0];
                    end
                end
            end
            rem_next[j] = rem_v;
            low_next[j] = low_v;
            quo_next[j] = quo_v;
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_src[j];
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next[j];
            low_reg[j] <= low_next[j];
            quo_reg[j] <= quo_next[j];
            len_reg[j] <= len_src[j];
            tag_reg[j] <= tag_src[j];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ----- rtl/plane_from_three_points.sv -----
// ----------------------------------------------------------------------------
// plane_from_three_points
// Plane hypothesis from three Q16.16 points: unit normal and offset.
// ----------------------------------------------------------------------------
// One item is taken in every cycle: busy stays low, and start alone moves an
// item in. Each item gives one result, shown on the result ports for one cycle
// with done high. Each item passes through the front stages, the square-root
// pipe (16 stages, two root bits each), the three-lane divider (one entry
// stage plus two quotient bits a stage) and the back stages. Results cannot
// be held off; the pipe never stalls. Collinear or degenerate points give
// plane_ok low with all other fields zero.
// ----------------------------------------------------------------------------
module plane_from_three_points #(
    parameter int COORD_FRAC_BITS  = plf_pkg::COORD_FRAC_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = plf_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] first_z,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic signed [31:0] second_z,
    input  logic signed [31:0] third_x,
    input  logic signed [31:0] third_y,
    input  logic signed [31:0] third_z,
    output logic               done,
    output logic               plane_ok,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic        [30:0] normal_z,
    output logic signed [40:0] plane_offset
);
    import plf_pkg::*;

    localparam int U_W   = 33;
    localparam int W_W   = 34;
    localparam int MAG_W = 67;
    localparam int DOT_W = 66;
    localparam logic signed [W_W-1:0] EPS_Q =
        W_W'(((1 << COORD_FRAC_BITS) + 500) / 1000);
    localparam logic signed [DOT_W-1:0] HALF = DOT_W'(1) << (NORMAL_FRAC_BITS - 1);

    typedef logic [2:0][MAG_W-1:0] plf_mag3_t;

    // Shift all three magnitudes left by k when the top k bits are all clear
    function automatic plf_mag3_t norm_by(input plf_mag3_t m, input int k);
        plf_mag3_t        r;
        logic [MAG_W-1:0] orw;
        r   = m;
        orw = m[0] | m[1] | m[2];
        if ((orw >> (MAG_W - k)) == '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r[i] = m[i] << k;
            end
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // ---------------- stage 1: edge vectors ----------------
    logic                  s1_valid_reg;
    plf_tag_t              s1_tag_reg;
    logic signed [U_W-1:0] s1_u_reg [3];
    logic signed [U_W-1:0] s1_v_reg [3];
    logic signed [W_W-1:0] s1_w_reg [3];
    plf_tag_t              s1_tag_next;
    logic signed [U_W-1:0] s1_u_next [3];
    logic signed [U_W-1:0] s1_v_next [3];
    logic signed [W_W-1:0] s1_w_next [3];

    // Form u = p1 - p0, v = p2 - p0 and the offset copy w = v + eps
    always_comb
    begin
        logic signed [31:0] p0_v [3];
        logic signed [31:0] p1_v [3];
        logic signed [31:0] p2_v [3];
        p0_v[0] = first_x;  p0_v[1] = first_y;  p0_v[2] = first_z;
        p1_v[0] = second_x; p1_v[1] = second_y; p1_v[2] = second_z;
        p2_v[0] = third_x;  p2_v[1] = third_y;  p2_v[2] = third_z;
        s1_tag_next.ok  = 1'b1;
        s1_tag_next.neg = '0;
        for (int i = 0; i < 3; i++)
        begin
            s1_tag_next.p0[i] = p0_v[i];
            s1_u_next[i] = U_W'(p1_v[i]) - U_W'(p0_v[i]);
            s1_v_next[i] = U_W'(p2_v[i]) - U_W'(p0_v[i]);
            s1_w_next[i] = W_W'(p2_v[i]) - W_W'(p0_v[i]) + EPS_Q;
        end
    end

    // ---------------- stage 2: products ----------------
    logic                    s2_valid_reg;
    plf_tag_t                s2_tag_reg;
    logic signed [MAG_W-1:0] s2_ca_reg [2];
    logic signed [MAG_W-1:0] s2_cb_reg [2];
    logic signed [MAG_W-2:0] s2_xa_reg [3];
    logic signed [MAG_W-2:0] s2_xb_reg [3];
    logic signed [MAG_W-1:0] s2_ca_next [2];
    logic signed [MAG_W-1:0] s2_cb_next [2];
    logic signed [MAG_W-2:0] s2_xa_next [3];
    logic signed [MAG_W-2:0] s2_xb_next [3];

    // Multiply the ratio-test terms and the cross-product terms
    always_comb
    begin
        s2_ca_next[0] = MAG_W'(s1_u_reg[0]) * MAG_W'(s1_w_reg[1]);
        s2_cb_next[0] = MAG_W'(s1_u_reg[1]) * MAG_W'(s1_w_reg[0]);
        s2_ca_next[1] = MAG_W'(s1_u_reg[1]) * MAG_W'(s1_w_reg[2]);
        s2_cb_next[1] = MAG_W'(s1_u_reg[2]) * MAG_W'(s1_w_reg[1]);
        for (int i = 0; i < 3; i++)
        begin
            s2_xa_next[i] = (MAG_W-1)'(s1_u_reg[(i + 1) % 3]) *
                            (MAG_W-1)'(s1_v_reg[(i + 2) % 3]);
            s2_xb_next[i] = (MAG_W-1)'(s1_u_reg[(i + 2) % 3]) *
                            (MAG_W-1)'(s1_v_reg[(i + 1) % 3]);
        end
    end

    // ---------------- stage 3: ratio test and cross product ----------------
    logic                    s3_valid_reg;
    plf_tag_t                s3_tag_reg;
    logic signed [MAG_W-1:0] s3_n_reg [3];
    plf_tag_t                s3_tag_next;
    logic signed [MAG_W-1:0] s3_n_next [3];

    always_comb
    begin
        s3_tag_next    = s2_tag_reg;
        s3_tag_next.ok = !((s2_ca_reg[0] == s2_cb_reg[0]) && (s2_ca_reg[1] == s2_cb_reg[1]));
        for (int i = 0; i < 3; i++)
        begin
            s3_n_next[i] = MAG_W'(s2_xa_reg[i]) - MAG_W'(s2_xb_reg[i]);
        end
    end

    // ---------------- stage 4: orient and take magnitudes ----------------
    logic      s4_valid_reg;
    plf_tag_t  s4_tag_reg;
    plf_mag3_t s4_m_reg;
    plf_tag_t  s4_tag_next;
    plf_mag3_t s4_m_next;

    // Flip every sign when the z component is negative
    always_comb
    begin
        s4_tag_next = s3_tag_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_tag_next.neg[i] = s3_n_reg[i][MAG_W-1] ^ s3_n_reg[2][MAG_W-1];
            s4_m_next[i] = s3_n_reg[i][MAG_W-1] ? MAG_W'(-s3_n_reg[i]) : MAG_W'(s3_n_reg[i]);
        end
    end

    // ---------------- stages 5 to 7: normalize ----------------
    logic      s5_valid_reg;
    plf_tag_t  s5_tag_reg;
    plf_mag3_t s5_m_reg;
    plf_tag_t  s5_tag_next;
    logic      s6_valid_reg;
    plf_tag_t  s6_tag_reg;
    plf_mag3_t s6_m_reg;
    logic      s7_valid_reg;
    plf_tag_t  s7_tag_reg;
    plf_mag3_t s7_m_reg;

    // Drop a zero-length normal
    always_comb
    begin
        s5_tag_next    = s4_tag_reg;
        s5_tag_next.ok = s4_tag_reg.ok && ((s4_m_reg[0] | s4_m_reg[1] | s4_m_reg[2]) != '0);
    end

    // ---------------- stage 8: scaled components and squares ----------------
    logic                s8_valid_reg;
    plf_tag_t            s8_tag_reg;
    logic [2:0][A_W-1:0] s8_a_reg;
    logic [2*A_W-1:0]    s8_sq_reg [3];
    logic [2:0][A_W-1:0] s8_a_next;
    logic [2*A_W-1:0]    s8_sq_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s8_a_next[i]  = s7_m_reg[i][MAG_W-1 -: A_W];
            s8_sq_next[i] = (2*A_W)'(s8_a_next[i]) * (2*A_W)'(s8_a_next[i]);
        end
    end

    // ---------------- stage 9: sum of squares ----------------
    logic         s9_valid_reg;
    plf_sq_side_t s9_side_reg;
    logic [SUM_W-1:0] s9_sum_reg;
    logic [SUM_W-1:0] s9_sum_next;

    assign s9_sum_next = SUM_W'(s8_sq_reg[0]) + SUM_W'(s8_sq_reg[1]) + SUM_W'(s8_sq_reg[2]);

    // Advance valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    // Advance payload of the front stages
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= s1_tag_next;
        s1_u_reg   <= s1_u_next;
        s1_v_reg   <= s1_v_next;
        s1_w_reg   <= s1_w_next;
        s2_tag_reg <= s1_tag_reg;
        s2_ca_reg  <= s2_ca_next;
        s2_cb_reg  <= s2_cb_next;
        s2_xa_reg  <= s2_xa_next;
        s2_xb_reg  <= s2_xb_next;
        s3_tag_reg <= s3_tag_next;
        s3_n_reg   <= s3_n_next;
        s4_tag_reg <= s4_tag_next;
        s4_m_reg   <= s4_m_next;
        s5_tag_reg <= s5_tag_next;
        s5_m_reg   <= norm_by(norm_by(s4_m_reg, 64), 32);
        s6_tag_reg <= s5_tag_reg;
        s6_m_reg   <= norm_by(norm_by(s5_m_reg, 16), 8);
        s7_tag_reg <= s6_tag_reg;
        s7_m_reg   <= norm_by(norm_by(norm_by(s6_m_reg, 4), 2), 1);
        s8_tag_reg <= s7_tag_reg;
        s8_a_reg   <= s8_a_next;
        s8_sq_reg  <= s8_sq_next;
        s9_side_reg.tag <= s8_tag_reg;
        s9_side_reg.a   <= s8_a_reg;
        s9_sum_reg <= s9_sum_next;
    end

    // ---------------- length and division ----------------
    logic             sq_valid;
    logic [LEN_W-1:0] sq_len;
    plf_sq_side_t     sq_side;
    logic                           dv_valid;
    logic [2:0][NORMAL_FRAC_BITS:0] dv_quo;
    plf_tag_t                       dv_tag;

    plf_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s9_valid_reg),
        .in_sum    (s9_sum_reg),
        .in_side   (s9_side_reg),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_side  (sq_side)
    );

    plf_div_pipe #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_a      (sq_side.a),
        .in_len    (sq_len),
        .in_tag    (sq_side.tag),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    // ---------------- back stages: sign, dot product, offset ----------------
    logic               p1_valid_reg;
    plf_tag_t           p1_tag_reg;
    logic signed [31:0] p1_q_reg [3];
    logic signed [31:0] p1_q_next [3];
    logic               p2_valid_reg;
    plf_tag_t           p2_tag_reg;
    logic signed [31:0] p2_q_reg [3];
    logic signed [63:0] p2_prod_reg [3];
    logic signed [63:0] p2_prod_next [3];
    logic               done_reg;
    logic               plane_ok_reg;
    logic signed [31:0] normal_x_reg;
    logic signed [31:0] normal_y_reg;
    logic        [30:0] normal_z_reg;
    logic signed [40:0] plane_offset_reg;
    logic signed [40:0] plane_offset_next;

    // Restore component signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_q_next[i] = dv_tag.neg[i] ? -$signed(32'(dv_quo[i])) : $signed(32'(dv_quo[i]));
        end
    end

    // Multiply each component by the first point
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p2_prod_next[i] = 64'(p1_q_reg[i]) * 64'($signed(p1_tag_reg.p0[i]));
        end
    end

    // Round the dot product half up and negate it
    always_comb
    begin
        logic signed [DOT_W-1:0] t_v;
        logic signed [DOT_W-1:0] d_v;
        t_v = DOT_W'(p2_prod_reg[0]) + DOT_W'(p2_prod_reg[1]) + DOT_W'(p2_prod_reg[2]) + HALF;
        d_v = -(t_v >>> NORMAL_FRAC_BITS);
        plane_offset_next = d_v[40:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= dv_valid;
            p2_valid_reg <= p1_valid_reg;
            done_reg     <= p2_valid_reg;
        end
    end

    // Hold results; zero every field of a rejected item
    always_ff @(posedge clk)
    begin
        p1_tag_reg  <= dv_tag;
        p1_q_reg    <= p1_q_next;
        p2_tag_reg  <= p1_tag_reg;
        p2_q_reg    <= p1_q_reg;
        p2_prod_reg <= p2_prod_next;
        plane_ok_reg     <= p2_tag_reg.ok;
        normal_x_reg     <= p2_tag_reg.ok ? p2_q_reg[0] : '0;
        normal_y_reg     <= p2_tag_reg.ok ? p2_q_reg[1] : '0;
        normal_z_reg     <= p2_tag_reg.ok ? p2_q_reg[2][30:0] : '0;
        plane_offset_reg <= p2_tag_reg.ok ? plane_offset_next : '0;
    end

    assign done         = done_reg;
    assign plane_ok     = plane_ok_reg;
    assign normal_x     = normal_x_reg;
    assign normal_y     = normal_y_reg;
    assign normal_z     = normal_z_reg;
    assign plane_offset = plane_offset_reg;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for plane_from_three_points. A table of directed point triples
// (extremes, collinear samples, a zero normal and a flipped normal) comes
// first. Random triples follow, half of them free and the rest small,
// collinear or near-degenerate. Every item taken has an expected plane, from
// the table or predicted in exact wide arithmetic, and is checked field by
// field against the result that leaves the pipe in order.
// ----------------------------------------------------------------------------
module tb_top;
    import plf_pkg::*;

    localparam int NFB        = NORMAL_FRAC_BITS_DEF;
    localparam int CFB        = COORD_FRAC_BITS_DEF;
    localparam longint EPS_Q  = ((64'sd1 << CFB) + 500) / 1000;
    localparam int N_RANDOM   = 500;
    localparam int DRAIN      = 60;
    localparam int LIMIT      = 200000;
    localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINC = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    typedef logic signed [31:0] triple_t [9];

    typedef struct {
        logic               ok;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic        [30:0] nz;
        logic signed [40:0] off;
    } plane_t;

    typedef struct {
        triple_t pt;
        bit      known;
        plane_t  want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] first_x, first_y, first_z;
    logic signed [31:0] second_x, second_y, second_z;
    logic signed [31:0] third_x, third_y, third_z;
    logic               done;
    logic               plane_ok;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic        [30:0] normal_z;
    logic signed [40:0] plane_offset;

    plane_t pending_planes[$];
    row_t   directed_rows[$];
    row_t   cur_row;
    bit     last_taken;
    int     n_errors;
    int     n_items;
    int     n_results;
    int     n_valid;
    int     cycles;

    plane_from_three_points dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .third_x      (third_x),
        .third_y      (third_y),
        .third_z      (third_z),
        .done         (done),
        .plane_ok     (plane_ok),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact plane from three points: ratio test, cross product, unit normal
    function automatic plane_t plane_of(triple_t c);
        logic signed [127:0] u[3], v[3], w[3], n[3];
        logic        [127:0] m[3];
        bit                  neg[3];
        logic        [63:0]  a[3], sum, len, cand, r;
        longint              q[3], dot, t, rnd, d;
        int                  maxlen, s;
        plane_t              res;
        res = '{1'b0, '0, '0, '0, '0};
        for (int i = 0; i < 3; i++)
        begin
            u[i] = 128'(c[3 + i]) - 128'(c[i]);
            v[i] = 128'(c[6 + i]) - 128'(c[i]);
            w[i] = v[i] + 128'(EPS_Q);
        end
        if (u[0] * w[1] == u[1] * w[0] && u[1] * w[2] == u[2] * w[1])
            return res;
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        // Point the normal upward
        if (n[2] < 0)
            for (int i = 0; i < 3; i++)
                n[i] = -n[i];
        maxlen = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = n[i] < 0;
            m[i]   = neg[i] ? -n[i] : n[i];
            for (int b = 127; b >= 0; b--)
                if (m[i][b])
                begin
                    if (b + 1 > maxlen)
                        maxlen = b + 1;
                    break;
                end
        end
        if (maxlen == 0)
            return res;
        // Scale to 31 significant bits, then take the integer root
        s   = maxlen - 31;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (s > 0) ? 64'(m[i] >> s) : 64'(m[i] << (-s));
            sum += a[i] * a[i];
        end
        len = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = len | (64'd1 << b);
            if (cand * cand <= sum)
                len = cand;
        end
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            r    = ((a[i] << NFB) + (len >> 1)) / len;
            q[i] = neg[i] ? -longint'(r) : longint'(r);
            dot += q[i] * longint'(c[i]);
        end
        // Round half up back to coordinate fraction, then negate
        t   = dot + (64'sd1 <<< (NFB - 1));
        rnd = t >>> NFB;
        d   = -rnd;
        res.ok  = 1'b1;
        res.nx  = q[0][31:0];
        res.ny  = q[1][31:0];
        res.nz  = q[2][30:0];
        res.off = d[40:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("MISMATCH result %0d %s: got %h want %h", n_results, what, got, want);
    endtask

    // Append one row to the directed table
    task automatic add_row(row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Count cycles, record acceptance, check results in order
    always @(posedge clk)
    begin
        plane_t exp_p;
        cycles     <= cycles + 1;
        last_taken <= start && !busy;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("** plane_from_three_points: FAILED **");
            $finish;
        end
        if (rst_n && done)
        begin
            if (pending_planes.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(plane_ok), 64'd0);
            end
            else
            begin
                exp_p = pending_planes.pop_front();
                if (plane_ok !== exp_p.ok)
                    report_mismatch("plane_ok", 64'(plane_ok), 64'(exp_p.ok));
                if (normal_x !== exp_p.nx)
                    report_mismatch("normal_x", 64'(normal_x), 64'(exp_p.nx));
                if (normal_y !== exp_p.ny)
                    report_mismatch("normal_y", 64'(normal_y), 64'(exp_p.ny));
                if (normal_z !== exp_p.nz)
                    report_mismatch("normal_z", 64'(normal_z), 64'(exp_p.nz));
                if (plane_offset !== exp_p.off)
                    report_mismatch("plane_offset", 64'(plane_offset), 64'(exp_p.off));
                if (exp_p.ok)
                    n_valid++;
            end
            n_results++;
        end
        if (rst_n && start && !busy)
        begin
            pending_planes.insert(pending_planes.size(),
                                  cur_row.known ? cur_row.want : plane_of(cur_row.pt));
            n_items++;
        end
    end

    task automatic put_item(row_t row);
        cur_row  = row;
        start    = 1'b1;
        first_x  = row.pt[0];
        first_y  = row.pt[1];
        first_z  = row.pt[2];
        second_x = row.pt[3];
        second_y = row.pt[4];
        second_z = row.pt[5];
        third_x  = row.pt[6];
        third_y  = row.pt[7];
        third_z  = row.pt[8];
    endtask

    // Drive one item at the falling edge, hold until taken, then idle a while
    task automatic send_item(row_t row, int gap);
        put_item(row);
        do @(negedge clk); while (!last_taken);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic row_t random_row(int kind);
        row_t row;
        int   k;
        row.known = 1'b0;
        row.want  = '{1'b0, '0, '0, '0, '0};
        for (int i = 0; i < 9; i++)
            row.pt[i] = $urandom;
        case (kind)
            // Small coordinates around zero
            1:
            begin
                for (int i = 0; i < 9; i++)
                    row.pt[i] = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            end
            // Collinear: third point on the line through the first two
            2:
            begin
                k = $urandom_range(0, 6) - 3;
                for (int i = 0; i < 3; i++)
                begin
                    row.pt[i]     = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                    row.pt[3 + i] = row.pt[i] + ($signed($urandom_range(0, 4095)) - 2048);
                    row.pt[6 + i] = row.pt[i] + k * (row.pt[3 + i] - row.pt[i]);
                end
            end
            // Nearly flat or repeated points
            3:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    row.pt[3 + i] = row.pt[i] + ($signed($urandom_range(0, 7)) - 3);
                    row.pt[6 + i] = ($urandom_range(0, 1)) ? row.pt[i] : row.pt[3 + i];
                end
            end
            default:
            begin
            end
        endcase
        return row;
    endfunction

    initial
    begin
        int gap;
        int kind;
        row_t row;
        plane_t reject;
        plane_t up_unit;
        reject  = '{1'b0, '0, '0, '0, '0};
        up_unit = '{1'b1, '0, '0, 31'sh4000_0000, '0};

        rst_n      = 1'b0;
        start      = 1'b0;
        cur_row    = '{'{default: '0}, 1'b1, reject};
        first_x    = '0;
        first_y    = '0;
        first_z    = '0;
        second_x   = '0;
        second_y   = '0;
        second_z   = '0;
        third_x    = '0;
        third_y    = '0;
        third_z    = '0;
        last_taken = 1'b0;
        n_errors   = 0;
        n_items    = 0;
        n_results  = 0;
        n_valid    = 0;
        cycles     = 0;

        // Directed table: expected plane where obvious, else predicted
        add_row('{'{default: 32'sd0}, 1'b1, reject});
        add_row('{'{5, 6, 7, 5, 6, 7, 5, 6, 7}, 1'b1, reject});
        add_row('{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1'b1, up_unit});
        add_row('{'{0, 0, 0, 0, ONE, 0, ONE, 0, 0}, 1'b1, up_unit});
        add_row('{'{0, 0, 0, 2, 4, 0, 1, 2, 0}, 1'b1, reject});
        add_row('{'{0, 0, 0, 2, 2, 2, 1, 1, 1}, 1'b1, reject});
        add_row('{'{0, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
                  '{1'b1, 32'sh4000_0000, '0, '0, '0}});
        add_row('{'{0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE}, 1'b1,
                  '{1'b1, '0, '0, 31'sh4000_0000, -41'sd65536}});
        add_row('{'{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC},
                  1'b0, reject});
        add_row('{'{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MAXC, MINC},
                  1'b0, reject});
        add_row('{'{MINC, MAXC, 0, MAXC, MINC, MAXC, 0, MINC, MINC},
                  1'b0, reject});
        add_row('{'{MAXC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC},
                  1'b0, reject});
        add_row('{'{ONE, -ONE, 3 * ONE, 2, -7, 9, -ONE, 5, -1},
                  1'b0, reject});
        add_row('{'{-1, -1, -1, 0, 0, 0, 1, -1, 1}, 1'b0, reject});

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i], $urandom_range(0, 3));

        // Random part: bursts without gaps alternate with idling stretches
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            kind = (kind < 5) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
            row  = random_row(kind);
            gap  = ((i / 64) % 2 == 1) ? 0 : $urandom_range(0, 7);
            send_item(row, gap);
        end
        start = 1'b0;

        // Drain the pipe
        while (pending_planes.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        $display("Sent %0d point triples, %0d results checked.", n_items, n_results);
        $display("%0d valid planes seen, %0d mismatches.", n_valid, n_errors);
        if (n_errors == 0)
            $display("** plane_from_three_points: PASSED **");
        else
            $display("** plane_from_three_points: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/plf_pkg.sv
rtl/plf_sqrt_pipe.sv
rtl/plf_div_pipe.sv
rtl/plane_from_three_points.sv
dv/tb_top.sv
